/* src/ohlcm_pkg.sv */
// Shared types, widths and helper functions for the OHLC bar bucket merger.
// No dependencies; imported by ohlcm_rem_div and ohlc_bar_bucket_merger.

package ohlcm_pkg;

    localparam int TIME_W   = 40;
    localparam int PRICE_W  = 63;
    localparam int UNIT_W   = 2;
    localparam int QTY_W    = 10;
    localparam int FRAME_W  = 27;                      // 1023 days in seconds fits
    localparam int DIVCNT_W = $clog2(TIME_W);
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = QTY_W;

    // stream word layout
    localparam int FIELDS_W     = 2 * TIME_W + 5 * PRICE_W;
    localparam int TDATA_W      = ((FIELDS_W + 7) / 8) * 8;
    localparam int IN_TUSER_W   = 1;
    localparam int OUT_TUSER_W  = 3;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_UNIT = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_QTY  = 1'b1;

    // frame unit codes
    localparam logic [UNIT_W-1:0] UNIT_MINUTE = 2'd0;
    localparam logic [UNIT_W-1:0] UNIT_HOUR   = 2'd1;
    localparam logic [UNIT_W-1:0] UNIT_DAY    = 2'd2;

    localparam logic [FRAME_W-1:0] SEC_PER_MINUTE = FRAME_W'(60);
    localparam logic [FRAME_W-1:0] SEC_PER_HOUR   = FRAME_W'(3600);
    localparam logic [FRAME_W-1:0] SEC_PER_DAY    = FRAME_W'(86400);

    typedef logic [TIME_W-1:0]  time_t;
    typedef logic [PRICE_W-1:0] price_t;
    typedef logic [FRAME_W-1:0] frame_t;

    typedef enum logic [1:0] {
        KIND_TENTATIVE = 2'd0,
        KIND_BACKFILL  = 2'd1,
        KIND_REPLACE   = 2'd2,
        KIND_NONE      = 2'd3
    } kind_t;

    // Bucket length in seconds; the unused unit code gives a zero frame.
    function automatic frame_t frame_seconds(input logic [UNIT_W-1:0] unit,
                                             input logic [QTY_W-1:0] qty);
        frame_t f;
        unique case (unit)
            UNIT_MINUTE: f = FRAME_W'(qty) * SEC_PER_MINUTE;
            UNIT_HOUR:   f = FRAME_W'(qty) * SEC_PER_HOUR;
            UNIT_DAY:    f = FRAME_W'(qty) * SEC_PER_DAY;
            default:     f = '0;
        endcase
        return f;
    endfunction

    // Bucket end, saturating at the top of the time range.
    function automatic time_t end_of(input time_t start, input frame_t frame);
        logic [TIME_W:0] s;
        s = {1'b0, start} + (TIME_W + 1)'(frame);
        return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
    endfunction

endpackage

/* src/ohlc_bar_bucket_merger.sv */
// Top level of the OHLC bar bucket merger: sequencer, bucket state, output word.
// Depends on ohlcm_pkg and ohlcm_rem_div.
//
// Usage:
//   s_axis carries one price bar per word; tlast marks the last bar of a batch
//   and tuser holds the bar's state (closed/forming). The first bar of a batch
//   is the anchor; every bar is snapped toward it onto a whole-frame grid.
//   m_axis carries merged buckets: tentative ones as a bucket completes, then
//   one classified bucket with tlast high at the end of each batch.
//   cfg_we/cfg_index/cfg_data write frame_unit (index 0) and frame_quantity
//   (index 1); write only between batches while no bar is in flight.
// Sequence:
//   Each bar passes the sequencer steps in order: diff, the bit-serial remainder
//   loop that snaps the open time (one time bit per cycle), snap, place, then
//   load or merge. A tentative bucket adds one step, the last bar of a batch
//   two (final calculation and final emit). A zero frame skips the loop.
//   s_axis_tready is high only while the sequencer is idle, so a new bar is
//   taken only after the sequencer is through with the last one.
// Reset: clears the batch and the stored previous bucket, frame 1 minute.
// Stall: a result sits in the output register until taken; the next bar is
//   still accepted, and the sequencer waits only when it must emit into a
//   full output register.

module ohlc_bar_bucket_merger (
    input  logic                              clk,
    input  logic                              rst_n,
    // cfg
    input  logic                              cfg_we,
    input  logic [ohlcm_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [ohlcm_pkg::CFG_DATA_W-1:0]  cfg_data,
    // bars in
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // start time, open_price, high_price, low_price, close_price, volume, now_time
    input  logic [ohlcm_pkg::TDATA_W-1:0]     s_axis_tdata,
    input  logic [ohlcm_pkg::IN_TUSER_W-1:0]  s_axis_tuser,  // bar_state
    input  logic                              s_axis_tlast,  // last_bar
    // buckets out
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // bucket_start, bucket_open, bucket_high, bucket_low, bucket_close,
    // bucket_volume, bucket_end
    output logic [ohlcm_pkg::TDATA_W-1:0]     m_axis_tdata,
    output logic [ohlcm_pkg::OUT_TUSER_W-1:0] m_axis_tuser,  // bucket_state, update_kind
    output logic                              m_axis_tlast   // last_result
);
    import ohlcm_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b00_0000_0001,
        S_DIFF  = 10'b00_0000_0010,
        S_DIV   = 10'b00_0000_0100,
        S_SNAP  = 10'b00_0000_1000,
        S_PLACE = 10'b00_0001_0000,
        S_TENT  = 10'b00_0010_0000,
        S_LOAD  = 10'b00_0100_0000,
        S_MERGE = 10'b00_1000_0000,
        S_FCALC = 10'b01_0000_0000,
        S_FINAL = 10'b10_0000_0000
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [UNIT_W-1:0] unit_reg;
    logic [QTY_W-1:0]  qty_reg;
    frame_t            frame;

    // accepted bar
    time_t  t_reg, now_reg;
    price_t op_reg, hi_reg, lo_reg, cl_reg, vol_reg;
    logic   bst_reg, last_reg;

    // batch and bucket state
    logic   in_batch_reg, in_batch_next;
    logic   prev_valid_reg, prev_valid_next;
    logic   neg_reg, zero_frame_reg;
    time_t  anchor_reg, start_reg, end_reg;
    time_t  cur_start_reg;
    price_t cur_open_reg, cur_high_reg, cur_low_reg, cur_close_reg, cur_vol_reg;
    logic   cur_state_reg;
    time_t  prev_start_reg, prev_end_reg;
    price_t prev_open_reg, prev_high_reg, prev_low_reg, prev_close_reg, prev_vol_reg;
    logic   prev_state_reg;

    // output word
    logic   out_valid_reg, out_valid_next;
    time_t  out_start_reg, out_end_reg;
    price_t out_open_reg, out_high_reg, out_low_reg, out_close_reg, out_vol_reg;
    logic   out_state_reg, out_last_reg;
    kind_t  out_kind_reg;

    // datapath
    time_t          anch, diff, snapped;
    logic           t_below;
    logic           div_start, div_busy, div_done;
    frame_t         div_rem, rem_sel;
    logic           slot_free, load_out;
    logic [PRICE_W:0] vol_sum;
    logic           fin_state, same;
    kind_t          fin_kind;

    assign frame = frame_seconds(unit_reg, qty_reg);

    // ---------------------------------------------------------------- config
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unit_reg <= UNIT_MINUTE;
            qty_reg  <= QTY_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_FRAME_UNIT: unit_reg <= cfg_data[UNIT_W-1:0];
                CFG_FRAME_QTY:  qty_reg  <= cfg_data;
                default:        unit_reg <= unit_reg;
            endcase
        end
    end

    // ------------------------------------------------------ snap arithmetic
    // The anchor is the bar itself when no batch is open.
    assign anch    = in_batch_reg ? anchor_reg : t_reg;
    assign t_below = t_reg < anch;
    assign diff    = t_below ? (anch - t_reg) : (t_reg - anch);

    // Start the remainder loop on the distance to the anchor; skip it for a
    // zero frame, where the bar is not snapped at all.
    assign div_start = (state_reg == S_DIFF) && (frame != '0);

    ohlcm_rem_div u_rem_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (diff),
        .divisor  (frame),
        .busy     (div_busy),
        .done     (div_done),
        .rem      (div_rem)
    );

    // Snapping toward the anchor moves the bar by the remainder.
    assign rem_sel = zero_frame_reg ? '0 : div_rem;
    assign snapped = neg_reg ? (t_reg + TIME_W'(rem_sel)) : (t_reg - TIME_W'(rem_sel));

    // --------------------------------------------------------- merge / final
    assign vol_sum = {1'b0, cur_vol_reg} + {1'b0, vol_reg};

    assign fin_state = end_reg > now_reg;
    assign same = (cur_open_reg  == prev_open_reg)  && (cur_high_reg == prev_high_reg) &&
                  (cur_low_reg   == prev_low_reg)   && (cur_close_reg == prev_close_reg) &&
                  (cur_vol_reg   == prev_vol_reg)   && (end_reg == prev_end_reg) &&
                  (fin_state     == prev_state_reg);

    always_comb
    begin
        priority if (!prev_valid_reg || cur_start_reg > prev_start_reg)
            fin_kind = KIND_BACKFILL;
        else if (cur_start_reg == prev_start_reg && !same)
            fin_kind = (fin_state || prev_state_reg) ? KIND_REPLACE : KIND_BACKFILL;
        else
            fin_kind = KIND_NONE;
    end

    // ------------------------------------------------------------ sequencer
    assign slot_free = !out_valid_reg || m_axis_tready;
    assign load_out  = slot_free && ((state_reg == S_TENT) || (state_reg == S_FINAL));

    always_comb
    begin
        state_next      = state_reg;
        in_batch_next   = in_batch_reg;
        prev_valid_next = prev_valid_reg;
        unique case (state_reg)
            S_IDLE:
                if (s_axis_tvalid)
                    state_next = S_DIFF;
            S_DIFF:
                state_next = (frame != '0) ? S_DIV : S_SNAP;
            S_DIV:
                if (div_done)
                    state_next = S_SNAP;
            S_SNAP:
                state_next = S_PLACE;
            S_PLACE:
                priority if (!in_batch_reg)
                    state_next = S_LOAD;
                else if (start_reg == cur_start_reg)
                    state_next = S_MERGE;
                else
                    state_next = S_TENT;
            S_TENT:
                if (slot_free)
                    state_next = S_LOAD;
            S_LOAD:
            begin
                in_batch_next = 1'b1;
                state_next    = last_reg ? S_FCALC : S_IDLE;
            end
            S_MERGE:
                state_next = last_reg ? S_FCALC : S_IDLE;
            S_FCALC:
                state_next = S_FINAL;
            S_FINAL:
                if (slot_free)
                begin
                    in_batch_next   = 1'b0;
                    prev_valid_next = 1'b1;
                    state_next      = S_IDLE;
                end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            in_batch_reg   <= 1'b0;
            prev_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            in_batch_reg   <= in_batch_next;
            prev_valid_reg <= prev_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // ------------------------------------------------------------- payload
    always_ff @(posedge clk)
    begin
        // capture the bar word
        if (state_reg == S_IDLE && s_axis_tvalid)
        begin
            t_reg    <= s_axis_tdata[0 +: TIME_W];
            op_reg   <= s_axis_tdata[TIME_W + 0 * PRICE_W +: PRICE_W];
            hi_reg   <= s_axis_tdata[TIME_W + 1 * PRICE_W +: PRICE_W];
            lo_reg   <= s_axis_tdata[TIME_W + 2 * PRICE_W +: PRICE_W];
            cl_reg   <= s_axis_tdata[TIME_W + 3 * PRICE_W +: PRICE_W];
            vol_reg  <= s_axis_tdata[TIME_W + 4 * PRICE_W +: PRICE_W];
            now_reg  <= s_axis_tdata[TIME_W + 5 * PRICE_W +: TIME_W];
            bst_reg  <= s_axis_tuser[0];
            last_reg <= s_axis_tlast;
        end

        // latch the anchor and the side of the anchor the bar lies on
        if (state_reg == S_DIFF)
        begin
            anchor_reg     <= anch;
            neg_reg        <= t_below;
            zero_frame_reg <= (frame == '0);
        end

        if (state_reg == S_SNAP)
            start_reg <= snapped;

        // open a new bucket from the bar
        if (state_reg == S_LOAD)
        begin
            cur_start_reg <= start_reg;
            cur_open_reg  <= op_reg;
            cur_high_reg  <= hi_reg;
            cur_low_reg   <= lo_reg;
            cur_close_reg <= cl_reg;
            cur_vol_reg   <= vol_reg;
            cur_state_reg <= bst_reg;
        end

        // fold the bar into the open bucket, volume saturating
        if (state_reg == S_MERGE)
        begin
            if (hi_reg > cur_high_reg)
                cur_high_reg <= hi_reg;
            if (lo_reg < cur_low_reg)
                cur_low_reg <= lo_reg;
            cur_close_reg <= cl_reg;
            cur_vol_reg   <= vol_sum[PRICE_W] ? {PRICE_W{1'b1}} : vol_sum[PRICE_W-1:0];
        end

        if (state_reg == S_FCALC)
            end_reg <= end_of(cur_start_reg, frame);

        // remember the classified bucket for the next batch
        if (state_reg == S_FINAL && slot_free)
        begin
            prev_start_reg <= cur_start_reg;
            prev_end_reg   <= end_reg;
            prev_open_reg  <= cur_open_reg;
            prev_high_reg  <= cur_high_reg;
            prev_low_reg   <= cur_low_reg;
            prev_close_reg <= cur_close_reg;
            prev_vol_reg   <= cur_vol_reg;
            prev_state_reg <= fin_state;
        end

        // load the output word
        if (load_out)
        begin
            out_start_reg <= cur_start_reg;
            out_open_reg  <= cur_open_reg;
            out_high_reg  <= cur_high_reg;
            out_low_reg   <= cur_low_reg;
            out_close_reg <= cur_close_reg;
            out_vol_reg   <= cur_vol_reg;
            if (state_reg == S_FINAL)
            begin
                out_end_reg   <= end_reg;
                out_state_reg <= fin_state;
                out_kind_reg  <= fin_kind;
                out_last_reg  <= 1'b1;
            end
            else
            begin
                out_end_reg   <= end_of(cur_start_reg, frame);
                out_state_reg <= cur_state_reg;
                out_kind_reg  <= KIND_TENTATIVE;
                out_last_reg  <= 1'b0;
            end
        end
    end

    // --------------------------------------------------------------- ports
    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {(TDATA_W - FIELDS_W)'(0), out_end_reg, out_vol_reg,
                            out_close_reg, out_low_reg, out_high_reg, out_open_reg,
                            out_start_reg};
    assign m_axis_tuser  = {out_kind_reg, out_state_reg};
    assign m_axis_tlast  = out_last_reg;

    // ----------------------------------------------------------- assertions
    a_tent_in_batch: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_TENT) |-> in_batch_reg)
        else $error("tentative bucket emitted outside a batch");

    a_final_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FINAL && load_out) |=> (!in_batch_reg && prev_valid_reg))
        else $error("final bucket did not close the batch");

    a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tuser[2:1] != KIND_TENTATIVE))
        else $error("final bucket marked tentative");

    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIV))
        else $error("remainder arrived outside the divide step");

    a_div_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV && !div_done) |-> div_busy)
        else $error("waiting on an idle divider");

endmodule

/* src/ohlcm_rem_div.sv */
// Bit-serial restoring divider that returns only the remainder.
// Depends on ohlcm_pkg for widths.

module ohlcm_rem_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [ohlcm_pkg::TIME_W-1:0]  dividend,
    input  logic [ohlcm_pkg::FRAME_W-1:0] divisor,
    output logic                          busy,
    output logic                          done,
    output logic [ohlcm_pkg::FRAME_W-1:0] rem
);
    import ohlcm_pkg::*;

    logic                busy_reg,  busy_next;
    logic                done_reg,  done_next;
    logic [DIVCNT_W-1:0] cnt_reg,   cnt_next;
    logic [TIME_W-1:0]   shift_reg, shift_next;
    logic [FRAME_W-1:0]  rem_reg,   rem_next;
    logic [FRAME_W-1:0]  div_reg,   div_next;
    logic [FRAME_W:0]    trial;

    // one dividend bit per cycle, MSB first
    assign trial = {rem_reg, shift_reg[TIME_W-1]};

    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        cnt_next   = cnt_reg;
        shift_next = shift_reg;
        rem_next   = rem_reg;
        div_next   = div_reg;
        if (start && !busy_reg)
        begin
            busy_next  = 1'b1;
            cnt_next   = '0;
            shift_next = dividend;
            rem_next   = '0;
            div_next   = divisor;
        end
        else if (busy_reg)
        begin
            shift_next = {shift_reg[TIME_W-2:0], 1'b0};
            if (trial >= {1'b0, div_reg})
                rem_next = FRAME_W'(trial - {1'b0, div_reg});
            else
                rem_next = trial[FRAME_W-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIVCNT_W'(TIME_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        rem_reg   <= rem_next;
        div_reg   <= div_next;
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign rem  = rem_reg;

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("remainder reported while still iterating");

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && div_reg != '0) |-> rem_reg < div_reg)
        else $error("remainder not below divisor");

    a_fell_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy_reg) |-> done_reg)
        else $error("divider stopped without finishing");

endmodule

/* dv/ohlc_bar_bucket_merger_tb.sv */
// Self-checking testbench for ohlc_bar_bucket_merger: directed batches, then random ones.
// Depends on ohlcm_pkg for widths and codes; predicts every bucket with its own model.

module ohlc_bar_bucket_merger_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import ohlcm_pkg::*;

    localparam int     RANDOM_ITEMS  = 550;
    localparam int     SETTLE_CYCLES = 64;
    localparam int     CYCLE_LIMIT   = 500000;
    localparam time_t  TIME_MAX      = '1;
    localparam price_t PX_MAX        = '1;
    localparam price_t PX_MID        = price_t'(64'd1000 << 32);

    // one price bar as it travels on s_axis
    typedef struct packed {
        time_t  bar_time;
        price_t open_price, high_price, low_price, close_price, volume;
        logic   bar_state;
        time_t  now_time;
        logic   last_bar;
    } bar_t;

    // one merged bucket as it travels on m_axis
    typedef struct packed {
        time_t  start_time;
        price_t open_px, high_px, low_px, close_px, vol;
        time_t  end_time;
        logic   state;
        kind_t  kind;
        logic   last;
    } bucket_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [TDATA_W-1:0]     s_axis_tdata;
    logic [IN_TUSER_W-1:0]  s_axis_tuser;
    logic                   s_axis_tlast;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [TDATA_W-1:0]     m_axis_tdata;
    logic [OUT_TUSER_W-1:0] m_axis_tuser;
    logic                   m_axis_tlast;

    // expected buckets, oldest first
    bucket_t pending_buckets[$];
    int      mismatch_cnt;
    int      cycle_cnt;

    // predictor copy of the configuration and the bucket state
    logic [UNIT_W-1:0] frm_unit;
    logic [QTY_W-1:0]  frm_qty;
    logic              in_batch;
    time_t             anchor_t;
    bucket_t           cur;
    logic              prev_valid;
    bucket_t           prev;

    // sender pacing
    int   burst_left;
    logic calm;

    ohlc_bar_bucket_merger i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Abort a hung run.
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("** ohlc_bar_bucket_merger: FAILED **");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Frame length in seconds; the spare unit code and a zero quantity give zero.
    function automatic logic [63:0] frame_len();
        case (frm_unit)
            UNIT_MINUTE: return 64'(frm_qty) * 64'd60;
            UNIT_HOUR:   return 64'(frm_qty) * 64'd3600;
            UNIT_DAY:    return 64'(frm_qty) * 64'd86400;
            default:     return 64'd0;
        endcase
    endfunction

    // Bucket end, clamped at the top of the time range.
    function automatic time_t end_after(input time_t start);
        logic [63:0] s;
        s = 64'(start) + frame_len();
        return (s > 64'(TIME_MAX)) ? TIME_MAX : s[TIME_W-1:0];
    endfunction

    // Snap a bar time onto the anchor grid; the quotient truncates toward zero,
    // so bars before the anchor snap upward toward it.
    function automatic time_t snap_time(input time_t t);
        logic [63:0] f;
        logic [63:0] d;
        f = frame_len();
        if (f == 0)
            return t;
        if (t >= anchor_t)
        begin
            d = 64'(t - anchor_t);
            return anchor_t + time_t'((d / f) * f);
        end
        d = 64'(anchor_t - t);
        return anchor_t - time_t'((d / f) * f);
    endfunction

    // Fold one accepted bar into the bucket state and queue the buckets it closes.
    task automatic merge_bar(input bar_t b);
        logic    fresh;
        logic    same;
        time_t   start;
        time_t   fin;
        logic    st;
        kind_t   kind;
        bucket_t res;
        fresh = !in_batch;
        if (fresh)
        begin
            anchor_t = b.bar_time;
            in_batch = 1'b1;
        end
        start = snap_time(b.bar_time);
        if (!fresh && start == cur.start_time)
        begin
            if (b.high_price > cur.high_px)
                cur.high_px = b.high_price;
            if (b.low_price < cur.low_px)
                cur.low_px = b.low_price;
            cur.close_px = b.close_price;
            cur.vol = (b.volume > PX_MAX - cur.vol) ? PX_MAX : cur.vol + b.volume;
        end
        else
        begin
            if (!fresh)
            begin
                // the open bucket is complete: emit it as tentative
                res          = cur;
                res.end_time = end_after(cur.start_time);
                res.kind     = KIND_TENTATIVE;
                res.last     = 1'b0;
                pending_buckets = {pending_buckets, res};
            end
            cur.start_time = start;
            cur.open_px    = b.open_price;
            cur.high_px    = b.high_price;
            cur.low_px     = b.low_price;
            cur.close_px   = b.close_price;
            cur.vol        = b.volume;
            cur.state      = b.bar_state;
        end
        if (b.last_bar)
        begin
            // classify the final bucket against the stored one
            fin  = end_after(cur.start_time);
            st   = fin > b.now_time;
            kind = KIND_NONE;
            if (!prev_valid || cur.start_time > prev.start_time)
                kind = KIND_BACKFILL;
            else if (cur.start_time == prev.start_time)
            begin
                same = cur.open_px == prev.open_px && cur.high_px == prev.high_px &&
                       cur.low_px == prev.low_px && cur.close_px == prev.close_px &&
                       cur.vol == prev.vol && fin == prev.end_time && st == prev.state;
                if (!same)
                    kind = (st || prev.state) ? KIND_REPLACE : KIND_BACKFILL;
            end
            res          = cur;
            res.end_time = fin;
            res.state    = st;
            res.kind     = kind;
            res.last     = 1'b1;
            pending_buckets = {pending_buckets, res};
            prev       = res;
            prev_valid = 1'b1;
            in_batch   = 1'b0;
        end
    endtask

    // ------------------------------------------------------------------
    // Result check: compare each accepted word with the oldest expectation
    // ------------------------------------------------------------------

    task automatic compare_field(input string name, input logic [63:0] want,
                                 input logic [63:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatch_cnt++;
        end
    endtask

    always @(posedge clk)
    begin : result_check
        bucket_t want;
        bucket_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.start_time = m_axis_tdata[0 +: TIME_W];
            got.open_px    = m_axis_tdata[TIME_W +: PRICE_W];
            got.high_px    = m_axis_tdata[TIME_W + PRICE_W +: PRICE_W];
            got.low_px     = m_axis_tdata[TIME_W + 2 * PRICE_W +: PRICE_W];
            got.close_px   = m_axis_tdata[TIME_W + 3 * PRICE_W +: PRICE_W];
            got.vol        = m_axis_tdata[TIME_W + 4 * PRICE_W +: PRICE_W];
            got.end_time   = m_axis_tdata[TIME_W + 5 * PRICE_W +: TIME_W];
            got.state      = m_axis_tuser[0];
            got.kind       = kind_t'(m_axis_tuser[2:1]);
            got.last       = m_axis_tlast;
            if (pending_buckets.size() == 0)
            begin
                $error("bucket word with nothing expected: start 0x%0h", got.start_time);
                mismatch_cnt++;
            end
            else
            begin
                want = pending_buckets.pop_front();
                compare_field("bucket_start", want.start_time, got.start_time);
                compare_field("bucket_open", want.open_px, got.open_px);
                compare_field("bucket_high", want.high_px, got.high_px);
                compare_field("bucket_low", want.low_px, got.low_px);
                compare_field("bucket_close", want.close_px, got.close_px);
                compare_field("bucket_volume", want.vol, got.vol);
                compare_field("bucket_end", want.end_time, got.end_time);
                compare_field("bucket_state", want.state, got.state);
                compare_field("update_kind", want.kind, got.kind);
                compare_field("last_result", want.last, got.last);
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver stalls: a random mode holds for a random span - always ready,
    // coin flip each cycle, or long stall runs.
    // ------------------------------------------------------------------

    initial
    begin : rx_stall
        int   mode;
        int   span;
        int   run;
        logic level;
        m_axis_tready = 1'b1;
        level = 1'b1;
        span  = 0;
        mode  = 0;
        forever
        begin
            if (span <= 0)
            begin
                mode = $urandom_range(0, 2);
                span = 200 + $urandom_range(0, 200);
            end
            case (mode)
                0:
                begin
                    level = 1'b1;
                    run   = 1;
                end
                1:
                begin
                    level = 1'($urandom_range(0, 1));
                    run   = 1;
                end
                default:
                begin
                    level = !level;
                    run   = level ? $urandom_range(1, 8) : $urandom_range(1, 30);
                end
            endcase
            repeat (run)
            begin
                @(negedge clk);
                m_axis_tready = level;
            end
            span -= run;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Present one bar, hold it until taken, then predict. Bursts end in a gap unless calm.
    task automatic send_bar(input bar_t b);
        int gap;
        @(negedge clk);
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = TDATA_W'({b.now_time, b.volume, b.close_price, b.low_price,
                                  b.high_price, b.open_price, b.bar_time});
        s_axis_tuser  = b.bar_state;
        s_axis_tlast  = b.last_bar;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        merge_bar(b);
        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = $urandom_range(1, 8);
            if ($urandom_range(0, 5) == 0)
                calm = !calm;
            gap = calm ? 0 : $urandom_range(0, 60);
            if (gap > 0)
            begin
                @(negedge clk);
                s_axis_tvalid = 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
    endtask

    // Drain: drop valid, wait for every expected bucket, then let a bar that
    // merges without output finish its pass.
    task automatic settle();
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        while (pending_buckets.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Register write; the predictor keeps only the field width.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        @(negedge clk);
        cfg_we    = 1'b0;
        if (idx == CFG_FRAME_UNIT)
            frm_unit = value[UNIT_W-1:0];
        else
            frm_qty = value[QTY_W-1:0];
    endtask

    function automatic bar_t mk_bar(input time_t t, input price_t op, input price_t hi,
                                    input price_t lo, input price_t cl, input price_t vol,
                                    input logic st, input time_t now, input logic last);
        bar_t b;
        b.bar_time    = t;
        b.open_price  = op;
        b.high_price  = hi;
        b.low_price   = lo;
        b.close_price = cl;
        b.volume      = vol;
        b.bar_state   = st;
        b.now_time    = now;
        b.last_bar    = last;
        return b;
    endfunction

    function automatic time_t rand_time();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[TIME_W-1:0];
    endfunction

    function automatic price_t rand_price();
        logic [63:0] r;
        r = {$urandom, $urandom};
        case ($urandom_range(0, 7))
            0:       return PX_MAX;
            1:       return '0;
            2:       return PX_MAX - price_t'($urandom_range(0, 1000));
            3, 4:    return r[PRICE_W-1:0];
            default: return price_t'(r[47:0]);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Merge within one minute bucket, volume saturation, time and price extremes,
    // end clamp at the top of the time range.
    task automatic test_merge_extremes();
        send_bar(mk_bar('0, PX_MAX, PX_MID, PX_MID, '0, PX_MAX - 5, 1'b1, rand_time(), 1'b0));
        send_bar(mk_bar(time_t'(59), price_t'(1), PX_MAX, '0, PX_MAX, price_t'(100), 1'b0,
                        rand_time(), 1'b0));
        send_bar(mk_bar(time_t'(60), PX_MID, PX_MID, PX_MID, PX_MID, '0, 1'b0, '0, 1'b1));
        send_bar(mk_bar(TIME_MAX, PX_MAX, PX_MAX, PX_MAX, PX_MAX, PX_MAX, 1'b1, TIME_MAX, 1'b1));
        settle();
    endtask

    // Every update kind against the stored bucket.
    task automatic test_update_kinds();
        // identical rerun: no update
        send_bar(mk_bar(TIME_MAX, PX_MAX, PX_MAX, PX_MAX, PX_MAX, PX_MAX, 1'b1, TIME_MAX, 1'b1));
        // new close, both closed: backfill
        send_bar(mk_bar(TIME_MAX, PX_MAX, PX_MAX, PX_MAX, PX_MID, PX_MAX, 1'b0, TIME_MAX, 1'b1));
        // now before the end makes it forming: replace
        send_bar(mk_bar(TIME_MAX, PX_MAX, PX_MAX, PX_MAX, PX_MID, PX_MAX, 1'b0, '0, 1'b1));
        // earlier start than stored: no update
        send_bar(mk_bar(time_t'(1000), PX_MID, PX_MID, '0, PX_MID, price_t'(7), 1'b0,
                        time_t'(5000), 1'b1));
        settle();
    endtask

    // Zero frame from the spare unit code (upper data bits set) and from quantity zero.
    task automatic test_zero_frame();
        write_reg(CFG_FRAME_UNIT, '1);
        send_bar(mk_bar(time_t'(500), PX_MID, PX_MID, PX_MID, PX_MID, price_t'(1), 1'b1,
                        rand_time(), 1'b0));
        send_bar(mk_bar(time_t'(500), price_t'(3), PX_MAX, price_t'(2), price_t'(9),
                        price_t'(1), 1'b0, rand_time(), 1'b0));
        send_bar(mk_bar(time_t'(400), price_t'(4), price_t'(5), price_t'(1), price_t'(2),
                        price_t'(3), 1'b0, time_t'(400), 1'b1));
        settle();
        write_reg(CFG_FRAME_UNIT, CFG_DATA_W'(UNIT_MINUTE));
        write_reg(CFG_FRAME_QTY, '0);
        send_bar(mk_bar(time_t'(777), PX_MID, PX_MID, PX_MID, PX_MID, PX_MID, 1'b1, '0, 1'b1));
        settle();
    endtask

    // Bars before the anchor snap toward it.
    task automatic test_before_anchor();
        write_reg(CFG_FRAME_UNIT, CFG_DATA_W'(UNIT_HOUR));
        write_reg(CFG_FRAME_QTY, CFG_DATA_W'(2));
        send_bar(mk_bar(time_t'(100000), PX_MID, PX_MID, PX_MID, PX_MID, price_t'(10), 1'b0,
                        rand_time(), 1'b0));
        send_bar(mk_bar(time_t'(100000 - 7199), PX_MID, PX_MAX, price_t'(1), price_t'(77),
                        price_t'(20), 1'b1, rand_time(), 1'b0));
        send_bar(mk_bar(time_t'(100000 - 7201), price_t'(5), price_t'(6), price_t'(4),
                        price_t'(5), price_t'(30), 1'b1, time_t'(100000), 1'b1));
        settle();
    endtask

    // Largest frame, then a register change between two bars of one batch.
    task automatic test_config_mid_batch();
        write_reg(CFG_FRAME_UNIT, CFG_DATA_W'(UNIT_DAY));
        write_reg(CFG_FRAME_QTY, CFG_DATA_W'(1023));
        send_bar(mk_bar(time_t'(10), PX_MID, PX_MID, PX_MID, PX_MID, price_t'(1), 1'b0,
                        rand_time(), 1'b0));
        send_bar(mk_bar(time_t'(10 + 86400), PX_MID, PX_MAX, PX_MID, price_t'(8),
                        price_t'(2), 1'b1, rand_time(), 1'b0));
        settle();
        write_reg(CFG_FRAME_UNIT, CFG_DATA_W'(UNIT_MINUTE));
        write_reg(CFG_FRAME_QTY, CFG_DATA_W'(1));
        send_bar(mk_bar(time_t'(10 + 86400), price_t'(9), price_t'(9), price_t'(9),
                        price_t'(9), price_t'(9), 1'b0, rand_time(), 1'b0));
        send_bar(mk_bar(time_t'(10 + 86430), price_t'(8), price_t'(12), price_t'(3),
                        price_t'(11), price_t'(4), 1'b1, time_t'(10 + 86400), 1'b1));
        settle();
    endtask

    // Random frame settings between batches.
    task automatic pick_config();
        logic [CFG_DATA_W-1:0] unit_word;
        int                    u;
        logic [QTY_W-1:0]      qty;
        u = $urandom_range(0, 7);
        unit_word = CFG_DATA_W'($urandom_range(0, 1023));
        unit_word[UNIT_W-1:0] = (u < 6) ? UNIT_W'(u % 3) : UNIT_W'(3);
        case ($urandom_range(0, 9))
            0:       qty = QTY_W'(1);
            1:       qty = QTY_W'(1023);
            2:       qty = '0;
            3, 4:    qty = QTY_W'($urandom_range(1, 1023));
            default: qty = QTY_W'($urandom_range(1, 5));
        endcase
        write_reg(CFG_FRAME_UNIT, unit_word);
        write_reg(CFG_FRAME_QTY, qty);
    endtask

    // Random batches: mostly time-ordered runs that merge and roll over buckets,
    // some jumps back before the anchor, and reruns of the previous batch to
    // reach the no-update and replace cases.
    task automatic test_random_batches();
        bar_t        batch[$];
        bar_t        b;
        int          sent;
        int          batches;
        int          nbars;
        int          last_i;
        logic [63:0] f;
        logic [63:0] t;
        logic [63:0] anchor_guess;
        sent    = 0;
        batches = 0;
        while (sent < RANDOM_ITEMS)
        begin
            if (batches % 8 == 7)
            begin
                settle();
                pick_config();
            end
            f = frame_len();
            if (batch.size() > 0 && $urandom_range(0, 4) == 0)
            begin
                // rerun the previous batch, now and then with the last bar nudged
                last_i = batch.size() - 1;
                case ($urandom_range(0, 2))
                    0:       batch[last_i].close_price = rand_price();
                    1:       batch[last_i].now_time = rand_time();
                    default: ;
                endcase
            end
            else
            begin
                batch.delete();
                nbars = $urandom_range(1, 6);
                case ($urandom_range(0, 3))
                    0:       t = 64'(rand_time());
                    1:       t = 64'($urandom_range(0, 1000));
                    2:       t = 64'(TIME_MAX) - 64'($urandom_range(0, 3 * f[31:0] + 2));
                    default: t = 64'($urandom);
                endcase
                anchor_guess = t;
                for (int i = 0; i < nbars; i++)
                begin
                    if (i > 0)
                    begin
                        case ($urandom_range(0, 5))
                            0:       t = t + 64'($urandom_range(f[31:0], 3 * f[31:0] + 1));
                            1:       t = anchor_guess - 64'($urandom_range(0, 2 * f[31:0] + 1));
                            default: t = t + 64'($urandom_range(0, f[31:0] / 2 + 1));
                        endcase
                    end
                    b.bar_time    = t[TIME_W-1:0];
                    b.open_price  = rand_price();
                    b.high_price  = rand_price();
                    b.low_price   = rand_price();
                    b.close_price = rand_price();
                    b.volume      = rand_price();
                    b.bar_state   = 1'($urandom_range(0, 1));
                    b.last_bar    = (i == nbars - 1);
                    if ($urandom_range(0, 1))
                        b.now_time = rand_time();
                    else
                        b.now_time = time_t'(t + 64'($urandom_range(0, f[31:0] + 2)));
                    batch = {batch, b};
                end
            end
            foreach (batch[i])
                send_bar(batch[i]);
            sent += batch.size();
            batches++;
        end
        settle();
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial
    begin
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        s_axis_tlast  = 1'b0;
        mismatch_cnt  = 0;
        cycle_cnt     = 0;
        burst_left    = 1;
        calm          = 1'b0;
        // predictor starts from the reset state: one-minute frames, nothing stored
        frm_unit   = UNIT_MINUTE;
        frm_qty    = QTY_W'(1);
        in_batch   = 1'b0;
        anchor_t   = '0;
        cur        = '0;
        prev_valid = 1'b0;
        prev       = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_merge_extremes();
        test_update_kinds();
        test_zero_frame();
        test_before_anchor();
        test_config_mid_batch();
        test_random_batches();

        if (mismatch_cnt == 0 && pending_buckets.size() == 0)
            $display("** ohlc_bar_bucket_merger: PASSED **");
        else
            $display("** ohlc_bar_bucket_merger: FAILED **");
        $finish;
    end

endmodule
